FILE: hdl/ramt_pkg.sv
// Shared types and constants for the range-assign range-max tree.
`default_nettype none
package ramt_pkg;

  localparam int DATA_W     = 32;
  localparam int RANGE_W    = 11;
  localparam int LEAVES_DEF = 1024;

  typedef enum logic {
    CMD_ASSIGN = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                       cmd;
    logic [RANGE_W-1:0]         range_start;
    logic [RANGE_W-1:0]         range_end;
    logic signed [DATA_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   max_value;
    logic                       none_in_range;
  } rsp_t;

  // One tree slot: written/pending bit plus value.
  typedef struct packed {
    logic                       ok;
    logic signed [DATA_W-1:0]   val;
  } slot_t;

  // One memory word: pending assignment and node maximum.
  typedef struct packed {
    slot_t pend;
    slot_t node;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_CHK,
    ST_PUSH_RD,
    ST_PUSH_W0,
    ST_PUSH_W1,
    ST_PUSH_W2,
    ST_MAIN,
    ST_QUERY_RD,
    ST_UPD_CHK,
    ST_UPD_RA,
    ST_UPD_RB
  } state_e;

endpackage
`default_nettype wire

FILE: hdl/range_assign_range_max_tree_core.sv
// Top level: lazy segment tree with range assign and range maximum.
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+------------------------------
//  command  | req_i                      | transfer when start_i && !busy_o
//  result   | res_o                      | one-cycle strobe res_valid_o
//
// After reset the node memory is swept clear, one node a cycle, all 2*TREE
// node addresses (TREE = LEAVES rounded up to a power of two); busy_o is high then.
// An empty range ends in ST_IDLE: an assign drops, a query answers none. Otherwise
// the item runs a top-down push-down pass over 2*LOG boundary nodes: a node
// that does not straddle the bound is only checked, one that does is read,
// and a pending assignment is written to both children and cleared. The main
// pass then climbs the tree by level shifts, applying assigns or reading query nodes (up to 2*LOG nodes). For
// assigns a bottom-up update pass visits 2*LOG nodes and rebuilds those that straddle.
// The memory's one read and one write port serialise these steps. The
// receiver cannot stall; the result strobe lasts one cycle and a new
// command may be taken in that cycle.
`default_nettype none
module range_assign_range_max_tree_core #(
  parameter int LEAVES = ramt_pkg::LEAVES_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  output logic         busy_o,
  input  wire ramt_pkg::req_t req_i,
  output logic         res_valid_o,
  output ramt_pkg::rsp_t res_o
);
  import ramt_pkg::*;

  localparam int LOG   = $clog2(LEAVES);
  localparam int TREE  = 1 << LOG;
  localparam int AW    = LOG + 1;          // node address
  localparam int PW    = LOG + 2;          // leaf bound, may reach 2*TREE
  localparam int LVL_W = $clog2(LOG + 1);

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic            side_q, side_d;
  logic [PW-1:0]   l_q, l_d, r_q, r_d, l0_q, l0_d, r0_q, r0_d;
  logic [AW-1:0]   node_q, node_d;
  cmd_e            cmd_q, cmd_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  slot_t           acc_q, acc_d;
  entry_t          ent_q, ent_d;
  logic            res_valid_q, res_valid_d;
  rsp_t            res_q, res_d;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata, mem_rdata;

  slot_t           best_a, best_y;

  logic [31:0]     s_ext, e_ext, s_sat, e_sat;
  logic [PW-1:0]   mask, bnd;
  logic            cond;
  logic [AW-1:0]   node_sel;
  logic            push_adv, upd_adv;

  ramt_mem #(.AW(AW), .DW($bits(entry_t))) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared compare: accumulates query reads and rebuilds parent maxima.
  ramt_best u_best (
    .a_i (best_a),
    .b_i (mem_rdata.node),
    .y_o (best_y)
  );

  assign best_a = (state_q == ST_UPD_RB) ? ent_q.node : acc_q;

  // Saturate both bounds to LEAVES.
  assign s_ext = 32'(req_i.range_start);
  assign e_ext = 32'(req_i.range_end);
  assign s_sat = (s_ext > 32'(LEAVES)) ? 32'(LEAVES) : s_ext;
  assign e_sat = (e_ext > 32'(LEAVES)) ? 32'(LEAVES) : e_ext;

  // Boundary node at the current level and whether it straddles the range.
  assign mask     = (PW'(1) << lvl_q) - PW'(1);
  assign bnd      = side_q ? r0_q : l0_q;
  assign cond     = (bnd & mask) != '0;
  assign node_sel = side_q ? AW'((r0_q - PW'(1)) >> lvl_q) : AW'(l0_q >> lvl_q);

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      lvl_q       <= '0;
      side_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lvl_q       <= lvl_d;
      side_q      <= side_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    l_q    <= l_d;
    r_q    <= r_d;
    l0_q   <= l0_d;
    r0_q   <= r0_d;
    node_q <= node_d;
    cmd_q  <= cmd_d;
    val_q  <= val_d;
    acc_q  <= acc_d;
    ent_q  <= ent_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    lvl_d       = lvl_q;
    side_d      = side_q;
    l_d         = l_q;
    r_d         = r_q;
    l0_d        = l0_q;
    r0_d        = r0_q;
    node_d      = node_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    acc_d       = acc_q;
    ent_d       = ent_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = node_q;
    mem_wdata   = '0;
    mem_raddr   = node_sel;
    push_adv    = 1'b0;
    upd_adv     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep every node to unwritten, nothing pending.
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(2 * TREE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_d = req_i.cmd;
          val_d = req_i.value;
          l_d   = PW'(s_sat) + PW'(TREE);
          r_d   = PW'(e_sat) + PW'(TREE);
          l0_d  = PW'(s_sat) + PW'(TREE);
          r0_d  = PW'(e_sat) + PW'(TREE);
          acc_d = '0;
          if (s_sat >= e_sat) begin
            // Empty range: assign drops, query answers none.
            if (req_i.cmd == CMD_QUERY) begin
              res_valid_d         = 1'b1;
              res_d.max_value     = '0;
              res_d.none_in_range = 1'b1;
            end
          end else begin
            lvl_d   = LVL_W'(LOG);
            side_d  = 1'b0;
            state_d = ST_PUSH_CHK;
          end
        end
      end
      ST_PUSH_CHK: begin
        node_d = node_sel;
        if (cond) begin
          state_d = ST_PUSH_RD;
        end else begin
          push_adv = 1'b1;
        end
      end
      ST_PUSH_RD: begin
        ent_d = mem_rdata;
        if (mem_rdata.pend.ok) begin
          state_d = ST_PUSH_W0;
        end else begin
          push_adv = 1'b1;
        end
      end
      ST_PUSH_W0: begin
        mem_we         = 1'b1;
        mem_waddr      = {node_q[AW-2:0], 1'b0};
        mem_wdata.pend = ent_q.pend;
        mem_wdata.node = ent_q.pend;
        state_d        = ST_PUSH_W1;
      end
      ST_PUSH_W1: begin
        mem_we         = 1'b1;
        mem_waddr      = {node_q[AW-2:0], 1'b1};
        mem_wdata.pend = ent_q.pend;
        mem_wdata.node = ent_q.pend;
        state_d        = ST_PUSH_W2;
      end
      ST_PUSH_W2: begin
        mem_we         = 1'b1;
        mem_waddr      = node_q;
        mem_wdata.pend = '0;
        mem_wdata.node = ent_q.node;
        push_adv       = 1'b1;
      end
      ST_MAIN: begin
        if (l_q >= r_q) begin
          if (cmd_q == CMD_QUERY) begin
            res_valid_d         = 1'b1;
            res_d.max_value     = acc_q.ok ? acc_q.val : '0;
            res_d.none_in_range = !acc_q.ok;
            state_d             = ST_IDLE;
          end else begin
            lvl_d   = LVL_W'(1);
            side_d  = 1'b0;
            state_d = ST_UPD_CHK;
          end
        end else if (l_q[0]) begin
          mem_raddr = AW'(l_q);
          l_d       = l_q + PW'(1);
          if (cmd_q == CMD_QUERY) begin
            state_d = ST_QUERY_RD;
          end else begin
            mem_we         = 1'b1;
            mem_waddr      = AW'(l_q);
            mem_wdata.pend = '{ok: 1'b1, val: val_q};
            mem_wdata.node = '{ok: 1'b1, val: val_q};
          end
        end else if (r_q[0]) begin
          mem_raddr = AW'(r_q - PW'(1));
          r_d       = r_q - PW'(1);
          if (cmd_q == CMD_QUERY) begin
            state_d = ST_QUERY_RD;
          end else begin
            mem_we         = 1'b1;
            mem_waddr      = AW'(r_q - PW'(1));
            mem_wdata.pend = '{ok: 1'b1, val: val_q};
            mem_wdata.node = '{ok: 1'b1, val: val_q};
          end
        end else begin
          l_d = l_q >> 1;
          r_d = r_q >> 1;
        end
      end
      ST_QUERY_RD: begin
        acc_d   = best_y;
        state_d = ST_MAIN;
      end
      ST_UPD_CHK: begin
        node_d    = node_sel;
        mem_raddr = {node_sel[AW-2:0], 1'b0};
        if (cond) begin
          state_d = ST_UPD_RA;
        end else begin
          upd_adv = 1'b1;
        end
      end
      ST_UPD_RA: begin
        ent_d     = mem_rdata;
        mem_raddr = {node_q[AW-2:0], 1'b1};
        state_d   = ST_UPD_RB;
      end
      ST_UPD_RB: begin
        // Rebuild the parent from both children; its pending bit is clear.
        mem_we         = 1'b1;
        mem_waddr      = node_q;
        mem_wdata.pend = '0;
        mem_wdata.node = best_y;
        upd_adv        = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Advance the push-down pass: left bound, right bound, next level down.
    if (push_adv) begin
      if (!side_q) begin
        side_d  = 1'b1;
        state_d = ST_PUSH_CHK;
      end else begin
        side_d = 1'b0;
        if (lvl_q == LVL_W'(1)) begin
          state_d = ST_MAIN;
        end else begin
          lvl_d   = lvl_q - LVL_W'(1);
          state_d = ST_PUSH_CHK;
        end
      end
    end

    // Advance the update pass toward the root.
    if (upd_adv) begin
      if (!side_q) begin
        side_d  = 1'b1;
        state_d = ST_UPD_CHK;
      end else begin
        side_d = 1'b0;
        if (lvl_q == LVL_W'(LOG)) begin
          state_d = ST_IDLE;
        end else begin
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = ST_UPD_CHK;
        end
      end
    end
  end

  // Hold the memory still while idle.
  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  // An accepted assign never produces a strobe.
  a_assign_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.cmd == CMD_ASSIGN) |=> !res_valid_o)
    else $error("result strobe after assign");

  // Level counter stays inside the tree during the boundary passes.
  a_lvl_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH_CHK || state_q == ST_UPD_CHK)
      |-> (lvl_q != '0 && lvl_q <= LVL_W'(LOG)))
    else $error("tree level out of range");

endmodule
`default_nettype wire

FILE: hdl/ramt_mem.sv
// Node memory: one write port, one registered read port.
`default_nettype none
module ramt_mem #(
  parameter int AW = 11,
  parameter int DW = 66
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hdl/ramt_best.sv
// Shared compare unit: larger of two slots, unwritten slots lose.
`default_nettype none
module ramt_best (
  input  wire ramt_pkg::slot_t a_i,
  input  wire ramt_pkg::slot_t b_i,
  output ramt_pkg::slot_t y_o
);
  import ramt_pkg::*;

  always_comb begin
    if (!a_i.ok) begin
      y_o = b_i;
    end else if (!b_i.ok) begin
      y_o = a_i;
    end else if ($signed(a_i.val) >= $signed(b_i.val)) begin
      y_o = a_i;
    end else begin
      y_o = b_i;
    end
  end

endmodule
`default_nettype wire

FILE: test/range_max_checker.sv
// Checker: predicts query results of the range-assign range-max tree and compares them.
`default_nettype none
module range_max_checker #(
  parameter int LEAVES = 1024
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            busy_i,
  input  wire ramt_pkg::req_t  req_i,
  input  wire logic            res_valid_i,
  input  wire ramt_pkg::rsp_t  res_i,
  output int                   fail_count_o,
  output int                   pending_count_o,
  output int                   query_count_o
);
  import ramt_pkg::*;

  // Flat element array: the tree's observable behavior equals it.
  logic                     elem_ok  [LEAVES];
  logic signed [DATA_W-1:0] elem_val [LEAVES];
  rsp_t                     expected_rsp_q[$];

  function automatic rsp_t range_max(input int s, input int e);
    rsp_t r;
    r.none_in_range = 1'b1;
    r.max_value     = '0;
    for (int i = s; i < e; i++) begin
      if (elem_ok[i] && (r.none_in_range || elem_val[i] > r.max_value)) begin
        r.max_value     = elem_val[i];
        r.none_in_range = 1'b0;
      end
    end
    return r;
  endfunction

  assign pending_count_o = expected_rsp_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    int   s, e;
    int   n_err;
    rsp_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < LEAVES; i++) begin
        elem_ok[i]  <= 1'b0;
        elem_val[i] <= '0;
      end
      fail_count_o  <= 0;
      query_count_o <= 0;
      expected_rsp_q.delete();
    end else begin
      n_err = 0;
      // Check first: a result strobe and a new transfer may share a cycle.
      if (res_valid_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result with no query outstanding");
          n_err++;
        end else begin
          exp_r = expected_rsp_q.pop_front();
          if (res_i.max_value !== exp_r.max_value) begin
            $error("max_value: expected %0d actual %0d",
                   exp_r.max_value, res_i.max_value);
            n_err++;
          end
          if (res_i.none_in_range !== exp_r.none_in_range) begin
            $error("none_in_range: expected %0b actual %0b",
                   exp_r.none_in_range, res_i.none_in_range);
            n_err++;
          end
        end
      end
      if (n_err != 0) begin
        fail_count_o <= fail_count_o + n_err;
      end
      if (start_i && !busy_i) begin
        s = (req_i.range_start > LEAVES) ? LEAVES : int'(req_i.range_start);
        e = (req_i.range_end > LEAVES) ? LEAVES : int'(req_i.range_end);
        if (req_i.cmd == CMD_QUERY) begin
          expected_rsp_q.push_back(range_max(s, e));
          query_count_o <= query_count_o + 1;
        end else begin
          for (int i = s; i < e; i++) begin
            elem_ok[i]  <= 1'b1;
            elem_val[i] <= req_i.value;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: test/tb_range_assign_range_max_tree_core.sv
// Testbench top: drives commands into the range-max tree and reports the verdict.
`default_nettype none
module tb_range_assign_range_max_tree_core;
  import ramt_pkg::*;

  localparam int LEAVES    = 1024;
  localparam int N_RANDOM  = 1300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t req_i = '0;
  logic res_valid_o;
  rsp_t res_o;
  int   fail_count, pending_count, query_count;
  int   assign_count = 0;

  range_assign_range_max_tree_core #(.LEAVES(LEAVES)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .res_valid_o, .res_o
  );

  range_max_checker #(.LEAVES(LEAVES)) u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_i,
    .res_valid_i(res_valid_o), .res_i(res_o),
    .fail_count_o(fail_count), .pending_count_o(pending_count),
    .query_count_o(query_count)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hold one command on the port until it transfers, then drop start.
  task automatic send_cmd(input cmd_e c, input int s, input int e, input int v);
    @(posedge clk_i);
    start_i            <= 1'b1;
    req_i.cmd          <= c;
    req_i.range_start  <= s[RANGE_W-1:0];
    req_i.range_end    <= e[RANGE_W-1:0];
    req_i.value        <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    start_i <= 1'b0;
    if (c == CMD_ASSIGN) assign_count++;
  endtask

  // Bias indices toward the tree edges and out-of-range indices.
  function automatic int pick_index();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(1024, 2047);
      1:       return $urandom_range(0, 3);
      2:       return $urandom_range(1020, 1024);
      default: return $urandom_range(0, 1024);
    endcase
  endfunction

  function automatic int pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int s, e, burst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unwritten tree, empty ranges, extremes, saturated bounds.
    send_cmd(CMD_QUERY, 0, 1024, 0);
    send_cmd(CMD_QUERY, 5, 5, 0);
    send_cmd(CMD_QUERY, 9, 3, 0);
    send_cmd(CMD_ASSIGN, 7, 7, 99);
    send_cmd(CMD_QUERY, 0, 1024, 0);
    send_cmd(CMD_ASSIGN, 0, 1, 32'h80000000);
    send_cmd(CMD_QUERY, 0, 1024, 0);
    send_cmd(CMD_ASSIGN, 1023, 2047, 32'h7fffffff);
    send_cmd(CMD_QUERY, 0, 1023, 0);
    send_cmd(CMD_QUERY, 1000, 2047, 0);
    send_cmd(CMD_QUERY, 2047, 2047, 0);
    send_cmd(CMD_ASSIGN, 0, 2047, -5);
    send_cmd(CMD_QUERY, 512, 513, 0);
    send_cmd(CMD_ASSIGN, 100, 300, 32'h55555555);
    send_cmd(CMD_ASSIGN, 200, 201, 32'haaaaaaaa);
    send_cmd(CMD_QUERY, 150, 250, 32'hffffffff);
    send_cmd(CMD_QUERY, 200, 201, 0);
    send_cmd(CMD_QUERY, 1024, 1024, 0);

    // Random: bursts back to back, then gaps of random length.
    for (int n = 0; n < N_RANDOM; n += burst) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        s = pick_index();
        e = ($urandom_range(0, 3) == 0) ? pick_index() : s + $urandom_range(0, 40);
        if (e > 2047) e = 2047;
        send_cmd(cmd_e'($urandom_range(0, 1)), s, e, pick_value());
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end

    // Drain the results, then let the block settle.
    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d assigns and %0d queries with bursty traffic.",
             assign_count, query_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
